// ===== hdl/weekly_alarm_table_matcher_defines.svh =====
// assertion helpers for the alarm table matcher
`ifndef WEEKLY_ALARM_TABLE_MATCHER_DEFINES_SVH
`define WEEKLY_ALARM_TABLE_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds whenever the trigger holds, same cycle
`define WATM_ASSERT_IMP(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");
// condition holds in the cycle after the trigger
`define WATM_ASSERT_NXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");
`else
`define WATM_ASSERT_IMP(lbl, trig, cond)
`define WATM_ASSERT_NXT(lbl, trig, cond)
`endif

`endif

// ===== hdl/wat_pkg.sv =====
package wat_pkg;

    localparam int unsigned ENTRIES = 16;
    localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_APPEND  = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_TRIGGER = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REJECT    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BUSY      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef enum logic {
        SCAN_TIME,
        SCAN_ID
    } scan_mode_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  track;
        logic [6:0]  mask;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        en;
    } entry_t;

    // what one table entry is compared against
    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        sec_ok;
    } key_t;

    // held count as the 5-bit result field
    function automatic logic [4:0] count_field(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+4:0] wide;
        wide = {5'd0, cnt};
        return wide[4:0];
    endfunction

endpackage

// ===== hdl/wat_store.sv =====
module wat_store (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [wat_pkg::IDX_W-1:0] wr_addr,
    input  wat_pkg::entry_t           wr_data,
    input  logic [wat_pkg::IDX_W-1:0] rd_addr,
    output wat_pkg::entry_t           rd_data
);

    wat_pkg::entry_t mem [wat_pkg::ENTRIES];
    wat_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/wat_match.sv =====
module wat_match (
    input  wat_pkg::scan_mode_t mode,
    input  wat_pkg::entry_t     ent,
    input  logic                ent_fired,
    input  wat_pkg::key_t       key,
    output logic                hit
);

    logic day_ok;
    logic time_hit;

    always_comb
    begin
        day_ok   = (key.weekday != 3'd0) && ent.mask[key.weekday - 3'd1];
        time_hit = ent.en && !ent_fired && day_ok && (ent.hour == key.hour)
                   && (ent.minute == key.minute) && key.sec_ok;
        case (mode)
            wat_pkg::SCAN_TIME: hit = time_hit;
            default:            hit = (ent.id == key.id);
        endcase
    end

endmodule

// ===== hdl/weekly_alarm_table_matcher.sv =====
// Weekly alarm table matcher: holds up to ENTRIES alarms (16) and answers every input
// transaction with exactly one result transaction. Clear, append and a tick that is blocked
// by the relay or meets an empty table go straight to the result state without a scan. Tick
// and manual trigger scan the table one entry per cycle through a single compare unit reading
// a registered-read entry memory; a tick that fires takes a second pass to locate the first
// entry with the fired id. The input side is not ready while an item is in work; a finished
// result waits in the output register and does not block the next acceptance.
`include "weekly_alarm_table_matcher_defines.svh"

module weekly_alarm_table_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_id[15:0], track[23:16], day_mask[30:24], enabled[31], weekday[34:32],
    // hour[39:35], minute[45:40], second[51:46], relay_busy[52], zero[55:53]
    input  logic [55:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // fired_id[15:0], fired_track[23:16], status[25:24], entry_count[30:26], zero[31]
    output logic [31:0] m_tdata,
    // fired[0]
    output logic        m_tuser
);

    localparam int unsigned CW = wat_pkg::CNT_W;
    localparam int unsigned IW = wat_pkg::IDX_W;

    // input unpacking
    wat_pkg::kind_t in_kind;
    logic [15:0]    in_id;
    logic [7:0]     in_track;
    logic [6:0]     in_mask;
    logic           in_en;
    logic [2:0]     in_wd;
    logic [4:0]     in_hour;
    logic [5:0]     in_minute;
    logic [5:0]     in_second;
    logic           in_busy;

    assign in_kind   = wat_pkg::kind_t'(s_tuser);
    assign in_id     = s_tdata[15:0];
    assign in_track  = s_tdata[23:16];
    assign in_mask   = s_tdata[30:24];
    assign in_en     = s_tdata[31];
    assign in_wd     = s_tdata[34:32];
    assign in_hour   = s_tdata[39:35];
    assign in_minute = s_tdata[45:40];
    assign in_second = s_tdata[51:46];
    assign in_busy   = s_tdata[52];

    // control state
    wat_pkg::state_t     state_reg, state_next;
    wat_pkg::scan_mode_t mode_reg, mode_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [2:0]          last_wd_reg, last_wd_next;
    logic [wat_pkg::ENTRIES-1:0] fired_bits_reg, fired_bits_next;
    logic [CW-1:0]       scan_idx_reg, scan_idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // payload
    logic [IW-1:0]       chk_idx_reg, chk_idx_next;
    wat_pkg::key_t       key_reg, key_next;
    logic                busy_reg, busy_next;
    logic                tick_reg, tick_next;
    logic [7:0]          fire_track_reg, fire_track_next;
    logic                res_fired_reg, res_fired_next;
    logic [15:0]         res_id_reg, res_id_next;
    logic [7:0]          res_track_reg, res_track_next;
    wat_pkg::status_t    res_status_reg, res_status_next;
    logic                out_fired_reg, out_fired_next;
    logic [15:0]         out_id_reg, out_id_next;
    logic [7:0]          out_track_reg, out_track_next;
    wat_pkg::status_t    out_status_reg, out_status_next;
    logic [4:0]          out_count_reg, out_count_next;

    // store and compare unit
    logic            wr_en;
    wat_pkg::entry_t wr_data;
    logic [IW-1:0]   rd_addr;
    wat_pkg::entry_t rd_data;
    logic            hit;
    logic            hit_vld;
    logic            issue;
    logic            accept;

    wat_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wat_match u_match (
        .mode      (mode_reg),
        .ent       (rd_data),
        .ent_fired (fired_bits_reg[chk_idx_reg]),
        .key       (key_reg),
        .hit       (hit)
    );

    assign s_tready = (state_reg == wat_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = scan_idx_reg[IW-1:0];
    assign hit_vld  = chk_vld_reg && hit;
    assign issue    = (scan_idx_reg < count_reg) && !hit_vld;

    assign wr_data.id     = in_id;
    assign wr_data.track  = in_track;
    assign wr_data.mask   = in_mask;
    assign wr_data.hour   = in_hour;
    assign wr_data.minute = in_minute;
    assign wr_data.en     = in_en;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        last_wd_next    = last_wd_reg;
        fired_bits_next = fired_bits_reg;
        scan_idx_next   = scan_idx_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        key_next        = key_reg;
        busy_next       = busy_reg;
        tick_next       = tick_reg;
        fire_track_next = fire_track_reg;
        res_fired_next  = res_fired_reg;
        res_id_next     = res_id_reg;
        res_track_next  = res_track_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_fired_next  = out_fired_reg;
        out_id_next     = out_id_reg;
        out_track_next  = out_track_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;

        unique case (state_reg)
            wat_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_fired_next  = 1'b0;
                    res_id_next     = 16'd0;
                    res_track_next  = 8'd0;
                    res_status_next = wat_pkg::ST_OK;
                    key_next.id      = in_id;
                    key_next.weekday = in_wd;
                    key_next.hour    = in_hour;
                    key_next.minute  = in_minute;
                    key_next.sec_ok  = (in_second < 6'd2);
                    busy_next        = in_busy;
                    tick_next        = (in_kind == wat_pkg::KIND_TICK);
                    scan_idx_next    = '0;
                    state_next       = wat_pkg::S_RESULT;
                    unique case (in_kind)
                        wat_pkg::KIND_CLEAR:
                        begin
                            fired_bits_next = '0;
                            count_next      = '0;
                            last_wd_next    = in_wd;
                        end
                        wat_pkg::KIND_APPEND:
                        begin
                            if ((count_reg >= wat_pkg::MAX_COUNT) || (in_id == 16'd0)
                                || (in_mask == 7'd0))
                            begin
                                res_status_next = wat_pkg::ST_REJECT;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                fired_bits_next[count_reg[IW-1:0]] = 1'b0;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        wat_pkg::KIND_TICK:
                        begin
                            if (in_busy)
                            begin
                                res_status_next = wat_pkg::ST_BUSY;
                            end
                            else if (count_reg != '0)
                            begin
                                // a new day re-arms every alarm
                                if (in_wd != last_wd_reg)
                                begin
                                    fired_bits_next = '0;
                                    last_wd_next    = in_wd;
                                end
                                mode_next  = wat_pkg::SCAN_TIME;
                                state_next = wat_pkg::S_SCAN;
                            end
                        end
                        wat_pkg::KIND_TRIGGER:
                        begin
                            mode_next  = wat_pkg::SCAN_ID;
                            state_next = wat_pkg::S_SCAN;
                        end
                    endcase
                end
            end

            wat_pkg::S_SCAN:
            begin
                if (hit_vld)
                begin
                    if (mode_reg == wat_pkg::SCAN_TIME)
                    begin
                        // second pass: the fired bit goes to the first entry with this id
                        key_next.id     = rd_data.id;
                        fire_track_next = rd_data.track;
                        mode_next       = wat_pkg::SCAN_ID;
                        scan_idx_next   = '0;
                    end
                    else
                    begin
                        state_next = wat_pkg::S_RESULT;
                        if (busy_reg)
                        begin
                            res_status_next = wat_pkg::ST_BUSY;
                        end
                        else
                        begin
                            fired_bits_next[chk_idx_reg] = 1'b1;
                            res_fired_next = 1'b1;
                            res_id_next    = key_reg.id;
                            res_track_next = tick_reg ? fire_track_reg : rd_data.track;
                        end
                    end
                end
                else if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_idx_reg[IW-1:0];
                end
                else if (!chk_vld_reg)
                begin
                    state_next = wat_pkg::S_RESULT;
                    if (mode_reg == wat_pkg::SCAN_ID)
                    begin
                        res_status_next = wat_pkg::ST_NOT_FOUND;
                    end
                end
            end

            wat_pkg::S_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_fired_next  = res_fired_reg;
                    out_id_next     = res_id_reg;
                    out_track_next  = res_track_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = wat_pkg::count_field(count_reg);
                    state_next      = wat_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = wat_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wat_pkg::S_IDLE;
            mode_reg       <= wat_pkg::SCAN_TIME;
            count_reg      <= '0;
            last_wd_reg    <= 3'd0;
            fired_bits_reg <= '0;
            scan_idx_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            last_wd_reg    <= last_wd_next;
            fired_bits_reg <= fired_bits_next;
            scan_idx_reg   <= scan_idx_next;
            chk_vld_reg    <= chk_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        key_reg        <= key_next;
        busy_reg       <= busy_next;
        tick_reg       <= tick_next;
        fire_track_reg <= fire_track_next;
        res_fired_reg  <= res_fired_next;
        res_id_reg     <= res_id_next;
        res_track_reg  <= res_track_next;
        res_status_reg <= res_status_next;
        out_fired_reg  <= out_fired_next;
        out_id_reg     <= out_id_next;
        out_track_reg  <= out_track_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_fired_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_status_reg, out_track_reg, out_id_reg};

    `WATM_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= wat_pkg::MAX_COUNT)
    `WATM_ASSERT_IMP(a_check_in_table, chk_vld_reg, CW'(chk_idx_reg) < count_reg)
    `WATM_ASSERT_IMP(a_fire_is_ok, m_tvalid_reg && out_fired_reg,
                     out_status_reg == wat_pkg::ST_OK)
    `WATM_ASSERT_NXT(a_fire_marks_entry,
                     (state_reg == wat_pkg::S_SCAN) && hit_vld
                     && (mode_reg == wat_pkg::SCAN_ID) && !busy_reg,
                     fired_bits_reg[$past(chk_idx_reg)])

endmodule

// ===== verif/weekly_alarm_table_matcher_tb.sv =====
module weekly_alarm_table_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GAP_MAX      = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 50;
    localparam int ITEM_TARGET  = 750;

    typedef struct {
        wat_pkg::kind_t kind;
        logic [15:0]    entry_id;
        logic [7:0]     track;
        logic [6:0]     day_mask;
        logic           enabled;
        logic [2:0]     weekday;
        logic [4:0]     hour;
        logic [5:0]     minute;
        logic [5:0]     second;
        logic           relay_busy;
    } alarm_item_t;

    typedef struct {
        logic             fired;
        logic [15:0]      fired_id;
        logic [7:0]       fired_track;
        wat_pkg::status_t status;
        logic [4:0]       entry_count;
    } alarm_response_t;

    // what an appended alarm can be aimed at later
    typedef struct {
        logic [15:0] id;
        logic [6:0]  mask;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } alarm_aim_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // alarm table as the testbench tracks it
    logic [15:0] tbl_id     [wat_pkg::ENTRIES];
    logic [7:0]  tbl_track  [wat_pkg::ENTRIES];
    logic [6:0]  tbl_mask   [wat_pkg::ENTRIES];
    logic [4:0]  tbl_hour   [wat_pkg::ENTRIES];
    logic [5:0]  tbl_minute [wat_pkg::ENTRIES];
    logic        tbl_en     [wat_pkg::ENTRIES];
    logic        tbl_fired  [wat_pkg::ENTRIES];
    int          held;
    logic [2:0]  day_seen;

    alarm_response_t pending_responses [$];
    int              mismatches;
    int              items_sent;
    int              idle_cycles;
    bit              burst_mode;

    weekly_alarm_table_matcher DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic alarm_response_t alarm_table_response(input alarm_item_t it);
        alarm_response_t r;
        int              hit;
        int              first;
        logic [7:0]      days;
        r.fired       = 1'b0;
        r.fired_id    = '0;
        r.fired_track = '0;
        r.status      = wat_pkg::ST_OK;
        hit           = -1;
        first         = -1;
        case (it.kind)
            wat_pkg::KIND_CLEAR:
            begin
                foreach (tbl_fired[i]) tbl_fired[i] = 1'b0;
                held     = 0;
                day_seen = it.weekday;
            end
            wat_pkg::KIND_APPEND:
            begin
                if (held >= wat_pkg::ENTRIES || it.entry_id == 0 || it.day_mask == 0)
                    r.status = wat_pkg::ST_REJECT;
                else
                begin
                    tbl_id[held]     = it.entry_id;
                    tbl_track[held]  = it.track;
                    tbl_mask[held]   = it.day_mask;
                    tbl_hour[held]   = it.hour;
                    tbl_minute[held] = it.minute;
                    tbl_en[held]     = it.enabled;
                    tbl_fired[held]  = 1'b0;
                    held++;
                end
            end
            wat_pkg::KIND_TICK:
            begin
                if (it.relay_busy)
                    r.status = wat_pkg::ST_BUSY;
                else if (held != 0)
                begin
                    if (it.weekday != day_seen)
                    begin
                        foreach (tbl_fired[i]) tbl_fired[i] = 1'b0;
                        day_seen = it.weekday;
                    end
                    for (int i = 0; i < held && hit < 0; i++)
                    begin
                        // weekday 0 lands on the padding bit and never matches
                        days = {tbl_mask[i], 1'b0};
                        if (tbl_en[i] && !tbl_fired[i] && days[it.weekday]
                                && tbl_hour[i] == it.hour && tbl_minute[i] == it.minute
                                && it.second < 2)
                            hit = i;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < held && hit < 0; i++)
                    if (tbl_id[i] == it.entry_id)
                        hit = i;
                if (hit < 0)
                    r.status = wat_pkg::ST_NOT_FOUND;
                else if (it.relay_busy)
                begin
                    r.status = wat_pkg::ST_BUSY;
                    hit      = -1;
                end
            end
        endcase
        if (hit >= 0)
        begin
            // the fired bit goes to the first entry with that id, not always the matched one
            for (int j = 0; j < held && first < 0; j++)
                if (tbl_id[j] == tbl_id[hit])
                    first = j;
            tbl_fired[first] = 1'b1;
            r.fired          = 1'b1;
            r.fired_id       = tbl_id[hit];
            r.fired_track    = tbl_track[hit];
        end
        r.entry_count = held[4:0];
        return r;
    endfunction

    function automatic alarm_item_t random_item();
        alarm_item_t it;
        it.kind       = wat_pkg::kind_t'($urandom_range(0, 3));
        it.entry_id   = 16'($urandom_range(0, 65535));
        it.track      = 8'($urandom_range(0, 255));
        it.day_mask   = 7'($urandom_range(0, 127));
        it.enabled    = 1'($urandom_range(0, 1));
        it.weekday    = 3'($urandom_range(0, 7));
        it.hour       = 5'($urandom_range(0, 31));
        it.minute     = 6'($urandom_range(0, 63));
        it.second     = 6'($urandom_range(0, 63));
        it.relay_busy = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // fields that the kind does not use keep random values
    function automatic alarm_item_t clear_item(input logic [2:0] wd);
        alarm_item_t it;
        it         = random_item();
        it.kind    = wat_pkg::KIND_CLEAR;
        it.weekday = wd;
        return it;
    endfunction

    function automatic alarm_item_t append_item(input logic [15:0] id, input logic [7:0] trk,
                                                input logic [6:0] mask, input logic en,
                                                input logic [4:0] hr, input logic [5:0] mn);
        alarm_item_t it;
        it          = random_item();
        it.kind     = wat_pkg::KIND_APPEND;
        it.entry_id = id;
        it.track    = trk;
        it.day_mask = mask;
        it.enabled  = en;
        it.hour     = hr;
        it.minute   = mn;
        return it;
    endfunction

    function automatic alarm_item_t tick_item(input logic [2:0] wd, input logic [4:0] hr,
                                              input logic [5:0] mn, input logic [5:0] sec,
                                              input logic busy);
        alarm_item_t it;
        it            = random_item();
        it.kind       = wat_pkg::KIND_TICK;
        it.weekday    = wd;
        it.hour       = hr;
        it.minute     = mn;
        it.second     = sec;
        it.relay_busy = busy;
        return it;
    endfunction

    function automatic alarm_item_t trigger_item(input logic [15:0] id, input logic busy);
        alarm_item_t it;
        it            = random_item();
        it.kind       = wat_pkg::KIND_TRIGGER;
        it.entry_id   = id;
        it.relay_busy = busy;
        return it;
    endfunction

    task automatic send_item(input alarm_item_t it);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {3'b000, it.relay_busy, it.second, it.minute, it.hour, it.weekday,
                     it.enabled, it.day_mask, it.track, it.entry_id};
        do @(posedge clk); while (!s_tready);
        pending_responses.push_back(alarm_table_response(it));
        items_sent++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_response();
        alarm_response_t want;
        if (pending_responses.size() == 0)
        begin
            $display("%0t: unexpected result transaction, expected none actual tdata %h tuser %b",
                     $time, m_tdata, m_tuser);
            mismatches++;
        end
        else
        begin
            want = pending_responses.pop_front();
            compare_field("fired", want.fired, m_tuser);
            compare_field("fired_id", want.fired_id, m_tdata[15:0]);
            compare_field("fired_track", want.fired_track, m_tdata[23:16]);
            compare_field("status", want.status, m_tdata[25:24]);
            compare_field("entry_count", want.entry_count, m_tdata[30:26]);
        end
    endtask

    initial
    begin : response_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = burst_mode ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_response();
        end
    end

    // ends the run when no transaction moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic test_empty_table();
        burst_mode = 1'b1;
        send_item(tick_item(3'd1, 5'd8, 6'd0, 6'd0, 1'b0));
        send_item(tick_item(3'd1, 5'd8, 6'd0, 6'd0, 1'b1));
        send_item(trigger_item(16'h1234, 1'b0));
        send_item(append_item(16'h0000, 8'h33, 7'h7F, 1'b1, 5'd8, 6'd0));
        send_item(append_item(16'h0007, 8'h11, 7'h00, 1'b1, 5'd8, 6'd0));
    endtask

    task automatic test_append_extremes();
        burst_mode = 1'b0;
        send_item(clear_item(3'd1));
        send_item(append_item(16'hFFFF, 8'hFF, 7'h7F, 1'b1, 5'd23, 6'd59));
        send_item(append_item(16'h0001, 8'h00, 7'h01, 1'b0, 5'd0, 6'd0));
        // out-of-range time, only a tick with the same values can fire it
        send_item(append_item(16'h0002, 8'h5A, 7'h40, 1'b1, 5'd31, 6'd63));
    endtask

    task automatic test_tick_matching();
        burst_mode = 1'b0;
        send_item(tick_item(3'd1, 5'd23, 6'd59, 6'd0, 1'b0));
        send_item(tick_item(3'd1, 5'd23, 6'd59, 6'd1, 1'b0));
        send_item(tick_item(3'd2, 5'd23, 6'd59, 6'd1, 1'b0));
        send_item(tick_item(3'd3, 5'd23, 6'd59, 6'd2, 1'b0));
        send_item(tick_item(3'd7, 5'd31, 6'd63, 6'd1, 1'b0));
        send_item(tick_item(3'd7, 5'd31, 6'd63, 6'd0, 1'b1));
        send_item(tick_item(3'd0, 5'd23, 6'd59, 6'd0, 1'b0));
    endtask

    task automatic test_manual_trigger();
        burst_mode = 1'b1;
        send_item(trigger_item(16'h0001, 1'b0));
        send_item(trigger_item(16'h0000, 1'b0));
        send_item(trigger_item(16'h0001, 1'b1));
        // missing id wins over busy relay
        send_item(trigger_item(16'hBEEF, 1'b1));
    endtask

    task automatic test_duplicate_ids();
        burst_mode = 1'b0;
        send_item(clear_item(3'd3));
        send_item(append_item(16'h0005, 8'h08, 7'h04, 1'b0, 5'd8, 6'd0));
        send_item(append_item(16'h0005, 8'h09, 7'h04, 1'b1, 5'd8, 6'd0));
        send_item(tick_item(3'd3, 5'd8, 6'd0, 6'd0, 1'b0));
        send_item(tick_item(3'd3, 5'd8, 6'd0, 6'd1, 1'b0));
    endtask

    task automatic test_random_sessions();
        alarm_item_t it;
        alarm_aim_t  aims [$];
        alarm_aim_t  pick;
        logic [2:0]  today;
        logic [15:0] id;
        logic [6:0]  mask;
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  sec;
        int          n_app;
        int          roll;
        while (items_sent < ITEM_TARGET)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            today = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 7));
            send_item(clear_item(today));
            aims.delete();
            // some sessions overfill the table
            n_app = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
            repeat (n_app)
            begin
                roll = $urandom_range(0, 99);
                id   = (roll < 60) ? 16'($urandom_range(1, 6)) :
                       (roll < 95) ? 16'($urandom_range(0, 65535)) : 16'h0000;
                mask = ($urandom_range(0, 99) < 8) ? 7'h00 : 7'($urandom_range(1, 127));
                hr   = ($urandom_range(0, 99) < 6) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 23));
                mn   = ($urandom_range(0, 99) < 6) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 59));
                it = append_item(id, 8'($urandom_range(0, 255)), mask,
                                 1'($urandom_range(0, 99) < 85), hr, mn);
                send_item(it);
                aims.push_back('{it.entry_id, it.day_mask, it.hour, it.minute});
            end
            repeat ($urandom_range(6, 16))
            begin
                roll = $urandom_range(0, 99);
                pick = aims[$urandom_range(0, aims.size() - 1)];
                if (roll < 60)
                begin
                    // aimed tick, sometimes moving to a day the alarm holds
                    if ($urandom_range(0, 9) < 3 && pick.mask != 0)
                        do today = 3'($urandom_range(1, 7)); while (!pick.mask[today - 3'd1]);
                    sec = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(0, 3));
                    send_item(tick_item(today, pick.hour, pick.minute, sec,
                                        1'($urandom_range(0, 9) == 0)));
                end
                else if (roll < 80)
                begin
                    id = ($urandom_range(0, 9) < 7) ? pick.id : 16'($urandom_range(0, 8));
                    send_item(trigger_item(id, 1'($urandom_range(0, 9) == 0)));
                end
                else if (roll < 90)
                begin
                    it      = random_item();
                    it.kind = wat_pkg::KIND_TICK;
                    send_item(it);
                end
                else
                    send_item(random_item());
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        mismatches = 0;
        items_sent = 0;
        burst_mode = 1'b0;
        held       = 0;
        day_seen   = '0;
        foreach (tbl_fired[i]) tbl_fired[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_append_extremes();
        test_tick_matching();
        test_manual_trigger();
        test_duplicate_ids();
        test_random_sessions();

        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_responses.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
